// ===== rtl/bid_pkg.sv =====
`timescale 1ns / 1ps

package bid_pkg;

  // default store depth and the shared widths
  localparam int unsigned DefCapacity = 16;
  localparam int unsigned ValueW      = 32;
  localparam int unsigned PosW        = 8;
  localparam int unsigned CountW      = 5;
  // position compare width: covers 8-bit positions and counts up to 256
  localparam int unsigned AtW         = 9;

  typedef enum logic [2:0] {
    MODE_PUSH_FRONT = 3'd0,
    MODE_PUSH_BACK  = 3'd1,
    MODE_POP_FRONT  = 3'd2,
    MODE_POP_BACK   = 3'd3,
    MODE_INSERT     = 3'd4,
    MODE_REMOVE     = 3'd5,
    MODE_CLEAR      = 3'd6
  } mode_e;

  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_EMPTY  = 2'd1,
    ST_FULL   = 2'd2,
    ST_BADPOS = 2'd3
  } status_e;

  // command broadcast to every cell of the row
  typedef struct packed {
    logic              ins;
    logic              rem;
    logic [AtW-1:0]    at;
    logic [ValueW-1:0] value;
  } cell_cmd_t;

endpackage

// ===== rtl/bid_cell.sv =====
`timescale 1ns / 1ps

module bid_cell #(
  parameter int unsigned Index = 0
) (
  input  logic                clk_i,
  input  bid_pkg::cell_cmd_t  cmd_i,
  input  logic [31:0]         left_i,
  input  logic [31:0]         right_i,
  output logic [31:0]         data_o
);
  import bid_pkg::*;

  localparam logic [AtW-1:0] IdxC = AtW'(Index);

  logic [ValueW-1:0] data_q, data_d;

  always_comb begin
    data_d = data_q;
    if (cmd_i.ins) begin
      if (IdxC == cmd_i.at) begin
        data_d = cmd_i.value;
      end else if (IdxC > cmd_i.at) begin
        data_d = left_i;
      end
    end else if (cmd_i.rem) begin
      if (IdxC >= cmd_i.at) begin
        data_d = right_i;
      end
    end
  end

  // entry data, no reset: undefined until written
  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  assign data_o = data_q;

endmodule

// ===== rtl/bounded_indexed_deque_core.sv =====
`timescale 1ns / 1ps

// Bounded deque with indexed insert and remove, holding up to Capacity signed
// 32-bit entries in a row of cells, position 0 at the front. Every transaction
// selects push front, push back, pop front, pop back, insert at a position,
// remove at a position or clear, and returns exactly one result carrying the
// removed value, a status (ok, empty, full, bad position) and the count after
// the operation (low 5 bits). Throughput is one transaction per clock while the
// receiver keeps out_ready high: every insertion or removal is a single shift of
// the whole cell row, and the result lands in one output register, so a new
// transaction is taken while the previous result is being handed off. The result
// becomes valid in the cycle after its transaction is taken. No clearing pass
// after reset: entries at or past the count are never read.
module bounded_indexed_deque_core #(
  parameter int unsigned Capacity = bid_pkg::DefCapacity
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [2:0]         mode_i,
  input  logic [7:0]         position_i,
  input  logic signed [31:0] item_value_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic signed [31:0] removed_value_o,
  output logic [1:0]         status_o,
  output logic [4:0]         count_o
);
  import bid_pkg::*;

  localparam int unsigned CntW = $clog2(Capacity + 1);
  localparam logic [CntW-1:0] CapC = CntW'(Capacity);

  // entry count
  logic [CntW-1:0] cnt_q, cnt_d;

  // output register
  logic              out_valid_q;
  logic [ValueW-1:0] removed_q, removed_d;
  status_e           status_q, status_d;
  logic [CountW-1:0] count_q;

  logic in_fire;
  logic full, empty;
  logic [AtW-1:0] cnt_ext, pos_ext;
  cell_cmd_t cmd;
  logic [ValueW-1:0] cell_data [Capacity];

  // take a new transaction whenever the output slot frees up this cycle
  assign in_ready_o = !out_valid_q || out_ready_i;
  assign in_fire    = in_valid_i && in_ready_o;

  assign full    = (cnt_q == CapC);
  assign empty   = (cnt_q == '0);
  assign cnt_ext = AtW'(cnt_q);
  assign pos_ext = AtW'(position_i);

  // decode: shift position, shift direction, status and next count
  always_comb begin
    cmd.ins   = 1'b0;
    cmd.rem   = 1'b0;
    cmd.at    = '0;
    cmd.value = item_value_i;
    status_d  = ST_OK;
    cnt_d     = cnt_q;
    unique case (mode_e'(mode_i)) inside
      MODE_PUSH_FRONT, MODE_PUSH_BACK, MODE_INSERT: begin
        if (full) begin
          status_d = ST_FULL;
        end else begin
          cmd.ins = 1'b1;
          cnt_d   = cnt_q + 1'b1;
          if (mode_e'(mode_i) == MODE_PUSH_FRONT) begin
            cmd.at = '0;
          end else if (mode_e'(mode_i) == MODE_PUSH_BACK) begin
            cmd.at = cnt_ext;
          end else begin
            // insert past the back clamps to the back
            cmd.at = (pos_ext >= cnt_ext) ? cnt_ext : pos_ext;
          end
        end
      end
      MODE_POP_FRONT, MODE_POP_BACK: begin
        if (empty) begin
          status_d = ST_EMPTY;
        end else begin
          cmd.rem = 1'b1;
          cnt_d   = cnt_q - 1'b1;
          cmd.at  = (mode_e'(mode_i) == MODE_POP_FRONT) ? '0 : (cnt_ext - 1'b1);
        end
      end
      MODE_REMOVE: begin
        // empty check wins over the position check
        if (empty) begin
          status_d = ST_EMPTY;
        end else if (pos_ext >= cnt_ext) begin
          status_d = ST_BADPOS;
        end else begin
          cmd.rem = 1'b1;
          cnt_d   = cnt_q - 1'b1;
          cmd.at  = pos_ext;
        end
      end
      MODE_CLEAR: begin
        cnt_d = '0;
      end
      default: begin
        // unused mode code: no operation
      end
    endcase
    if (!in_fire) begin
      cmd.ins = 1'b0;
      cmd.rem = 1'b0;
      cnt_d   = cnt_q;
    end
  end

  // row of cells, each shifting toward its neighbor on insert or remove
  for (genvar i = 0; i < Capacity; i++) begin : g_cell
    logic [ValueW-1:0] left, right;
    if (i == 0) begin : g_first
      assign left = item_value_i;
    end else begin : g_left
      assign left = cell_data[i-1];
    end
    if (i == Capacity - 1) begin : g_last
      assign right = cell_data[i];
    end else begin : g_right
      assign right = cell_data[i+1];
    end
    bid_cell #(
      .Index (i)
    ) u_cell (
      .clk_i   (clk_i),
      .cmd_i   (cmd),
      .left_i  (left),
      .right_i (right),
      .data_o  (cell_data[i])
    );
  end

  // value leaving the row: the cell at the removal position
  always_comb begin
    removed_d = '0;
    for (int i = 0; i < Capacity; i++) begin
      if (cmd.rem && (AtW'(i) == cmd.at)) begin
        removed_d = cell_data[i];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      cnt_q <= cnt_d;
      if (in_fire) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // result payload
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      removed_q <= removed_d;
      status_q  <= status_d;
      count_q   <= CountW'(cnt_d);
    end
  end

  assign out_valid_o     = out_valid_q;
  assign removed_value_o = removed_q;
  assign status_o        = status_q;
  assign count_o         = count_q;

  // count stays within the store depth
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CapC)
    else $error("entry count exceeds capacity");

  // a transaction is never taken while a stalled result occupies the output
  a_no_overrun: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(in_fire && out_valid_q && !out_ready_i))
    else $error("input transaction overwrote a pending result");

  // a failed operation never reports a value
  a_fail_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && status_q != ST_OK) |-> removed_q == '0)
    else $error("non-ok result carries a removed value");

  // a successful insertion grows the count by exactly one
  a_ins_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.ins |=> cnt_q == $past(cnt_q) + 1'b1)
    else $error("insert did not advance the count");

endmodule

// ===== sim/deque_checker.sv =====
`timescale 1ns / 1ps

module deque_checker #(
  parameter int unsigned Capacity = bid_pkg::DefCapacity
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  input  logic               in_ready_i,
  input  logic [2:0]         mode_i,
  input  logic [7:0]         position_i,
  input  logic signed [31:0] item_value_i,
  input  logic               out_valid_i,
  input  logic               out_ready_i,
  input  logic signed [31:0] removed_value_i,
  input  logic [1:0]         status_i,
  input  logic [4:0]         count_i,
  output int                 fail_cnt_o,
  output int                 pending_o,
  output int                 checked_o,
  output int                 empty_hits_o,
  output int                 full_hits_o,
  output int                 badpos_hits_o
);
  import bid_pkg::*;

  typedef struct packed {
    logic signed [ValueW-1:0] value;
    status_e                  status;
    logic [CountW-1:0]        count;
  } outcome_t;

  // mirror of the stored row, front at index 0
  logic signed [ValueW-1:0] cells [$];
  outcome_t                 due_results [$];
  outcome_t                 want;
  int fail_cnt    = 0;
  int checked     = 0;
  int empty_hits  = 0;
  int full_hits   = 0;
  int badpos_hits = 0;

  assign fail_cnt_o    = fail_cnt;
  assign pending_o     = due_results.size();
  assign checked_o     = checked;
  assign empty_hits_o  = empty_hits;
  assign full_hits_o   = full_hits;
  assign badpos_hits_o = badpos_hits;

  task automatic report_mismatch(input string msg);
    $display("%0t ns: mismatch: %s", $time, msg);
    fail_cnt++;
  endtask

  // applies one transaction to the mirror and returns the result it must give
  function automatic outcome_t mirror_op(input logic [2:0] m, input logic [7:0] p,
                                         input logic signed [ValueW-1:0] v);
    int unsigned n;
    outcome_t    r;
    n        = cells.size();
    r.value  = '0;
    r.status = ST_OK;
    case (m) inside
      MODE_PUSH_FRONT, MODE_PUSH_BACK, MODE_INSERT: begin
        if (n >= Capacity) begin
          r.status = ST_FULL;
        end else if (m == MODE_PUSH_FRONT) begin
          cells.push_front(v);
        end else if (m == MODE_PUSH_BACK || p >= n) begin
          cells.push_back(v);
        end else begin
          cells.insert(int'(p), v);
        end
      end
      MODE_POP_FRONT: begin
        if (n == 0) r.status = ST_EMPTY;
        else r.value = cells.pop_front();
      end
      MODE_POP_BACK: begin
        if (n == 0) r.status = ST_EMPTY;
        else r.value = cells.pop_back();
      end
      MODE_REMOVE: begin
        if (n == 0) begin
          r.status = ST_EMPTY;
        end else if (p >= n) begin
          r.status = ST_BADPOS;
        end else begin
          r.value = cells[p];
          cells.delete(int'(p));
        end
      end
      MODE_CLEAR: cells.delete();
      default: ;
    endcase
    r.count = CountW'(cells.size());
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cells.delete();
      due_results.delete();
    end else begin
      // results first: a result at this edge belongs to an earlier transaction
      if (out_valid_i && out_ready_i) begin
        checked++;
        if (status_i == ST_EMPTY) empty_hits++;
        if (status_i == ST_FULL) full_hits++;
        if (status_i == ST_BADPOS) badpos_hits++;
        if (due_results.size() == 0) begin
          report_mismatch($sformatf("result with nothing pending (value %0d status %0d count %0d)",
                                    removed_value_i, status_i, count_i));
        end else begin
          want = due_results.pop_front();
          if (removed_value_i !== want.value)
            report_mismatch($sformatf("removed value %0d, expected %0d",
                                      removed_value_i, $signed(want.value)));
          if (status_i !== want.status)
            report_mismatch($sformatf("status %0d, expected %0d", status_i, want.status));
          if (count_i !== want.count)
            report_mismatch($sformatf("count %0d, expected %0d", count_i, want.count));
        end
      end
      if (in_valid_i && in_ready_i)
        due_results.push_back(mirror_op(mode_i, position_i, item_value_i));
    end
  end

endmodule

// ===== sim/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;
  import bid_pkg::*;

  // mode code that the block treats as a no-op
  localparam logic [2:0] ModeUnused = 3'd7;
  localparam int NumItems   = 900;
  localparam int HoldCycles = 60;   // long receiver hold-off, fills the block up
  localparam int StallLimit = 1000; // cycles with no transaction before giving up

  typedef enum int {PH_FILL, PH_DRAIN, PH_MIXED} phase_e;

  logic               clk;
  logic               rst_n        = 1'b0;
  logic               in_valid     = 1'b0;
  logic               in_ready;
  logic [2:0]         mode         = MODE_CLEAR;
  logic [7:0]         position     = '0;
  logic signed [31:0] item_value   = '0;
  logic               out_valid;
  logic               out_ready    = 1'b0;
  logic signed [31:0] removed_value;
  logic [1:0]         status;
  logic [4:0]         count;

  int fail_cnt, pending, checked, empty_hits, full_hits, badpos_hits;
  int sent        = 0;
  int stall_cycles = 0;
  bit hold_req    = 1'b0;  // set by the sender side, served by the receiver process
  bit tx_quiet    = 1'b0;  // sender stretch with no gaps

  bounded_indexed_deque_core i_dut (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .in_valid_i     (in_valid),
    .in_ready_o     (in_ready),
    .mode_i         (mode),
    .position_i     (position),
    .item_value_i   (item_value),
    .out_valid_o    (out_valid),
    .out_ready_i    (out_ready),
    .removed_value_o(removed_value),
    .status_o       (status),
    .count_o        (count)
  );

  // watches both channels, mirrors the store and checks every result
  deque_checker i_checker (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .in_valid_i     (in_valid),
    .in_ready_i     (in_ready),
    .mode_i         (mode),
    .position_i     (position),
    .item_value_i   (item_value),
    .out_valid_i    (out_valid),
    .out_ready_i    (out_ready),
    .removed_value_i(removed_value),
    .status_i       (status),
    .count_i        (count),
    .fail_cnt_o     (fail_cnt),
    .pending_o      (pending),
    .checked_o      (checked),
    .empty_hits_o   (empty_hits),
    .full_hits_o    (full_hits),
    .badpos_hits_o  (badpos_hits)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // watchdog: any transaction on either channel resets the count
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && in_ready) || (out_valid && out_ready)) begin
        stall_cycles <= 0;
      end else begin
        stall_cycles <= stall_cycles + 1;
        if (stall_cycles >= StallLimit) begin
          $display("timeout: no transaction for %0d cycles", stall_cycles);
          $display("CHECKS FAILED");
          $finish;
        end
      end
    end
  end

  // offer one transaction and hold it until the block takes it;
  // ready is read right after the edge, so it is still the pre-edge value
  task automatic send_txn(input logic [2:0] m, input logic [7:0] p,
                          input logic signed [31:0] v);
    in_valid   <= 1'b1;
    mode       <= m;
    position   <= p;
    item_value <= v;
    do @(posedge clk); while (!in_ready);
    sent++;
  endtask

  // random gap after a transaction: mostly none, sometimes short, rarely long
  task automatic sender_gap();
    int r;
    int n;
    r = $urandom_range(0, 99);
    if (tx_quiet || r < 65) n = 0;
    else if (r < 95) n = $urandom_range(1, 3);
    else n = $urandom_range(8, 30);
    if (n > 0) begin
      in_valid <= 1'b0;
      repeat (n) @(posedge clk);
    end
  endtask

  function automatic logic [2:0] push_kind();
    case ($urandom_range(0, 2))
      0:       return MODE_PUSH_FRONT;
      1:       return MODE_PUSH_BACK;
      default: return MODE_INSERT;
    endcase
  endfunction

  function automatic logic [2:0] pull_kind();
    case ($urandom_range(0, 2))
      0:       return MODE_POP_FRONT;
      1:       return MODE_POP_BACK;
      default: return MODE_REMOVE;
    endcase
  endfunction

  // operation mix follows the phase so the store really fills and empties
  function automatic logic [2:0] pick_mode(input phase_e ph);
    int r;
    r = $urandom_range(0, 99);
    case (ph)
      PH_FILL:  return (r < 85) ? push_kind() : pull_kind();
      PH_DRAIN: return (r < 85) ? pull_kind() : push_kind();
      default: begin
        if (r < 3) return MODE_CLEAR;
        if (r < 5) return ModeUnused;
        return (r < 52) ? push_kind() : pull_kind();
      end
    endcase
  endfunction

  // receiver: random ready with quiet stretches and one long hold on request
  initial begin
    int  r;
    int  span;
    bit  rx_quiet;
    span     = 0;
    rx_quiet = 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if (span == 0) begin
        rx_quiet = ($urandom_range(0, 3) == 0);
        span     = $urandom_range(50, 150);
      end
      span--;
      r = $urandom_range(0, 99);
      if (hold_req) begin
        // hold off long enough that the block backs up and drops in_ready
        hold_req = 1'b0;
        out_ready <= 1'b0;
        repeat (HoldCycles) @(posedge clk);
      end else if (rx_quiet || r < 70) begin
        out_ready <= 1'b1;
        @(posedge clk);
      end else if (r < 95) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 3)) @(posedge clk);
      end else begin
        out_ready <= 1'b0;
        repeat ($urandom_range(8, 30)) @(posedge clk);
      end
    end
  end

  // stimulus: reset, directed corner cases, then phased random traffic
  initial begin
    int                 k;
    int                 phase_len;
    phase_e             ph;
    logic [2:0]         m;
    logic [7:0]         p;
    logic signed [31:0] v;

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // empty store: pops and remove report empty, no-op code keeps count 0
    send_txn(MODE_POP_FRONT, 8'd0, 32'sd0);
    send_txn(MODE_POP_BACK, 8'd0, 32'sd0);
    send_txn(MODE_REMOVE, 8'd255, 32'sd0);
    send_txn(ModeUnused, 8'd0, 32'sd0);

    // fill to capacity with every push flavor, extreme positions and values
    for (k = 0; k < 16; k++) begin
      case (k % 3)
        0:       m = MODE_PUSH_FRONT;
        1:       m = MODE_PUSH_BACK;
        default: m = MODE_INSERT;
      endcase
      case (k % 4)
        0:       p = 8'd0;
        1:       p = 8'd255;
        2:       p = 8'(k / 2);
        default: p = 8'd1;
      endcase
      case (k)
        0:       v = 32'sh8000_0000;
        1:       v = 32'sh7fff_ffff;
        2:       v = -32'sd1;
        3:       v = 32'sd0;
        default: v = $urandom;
      endcase
      send_txn(m, p, v);
    end

    // full store refuses all three insert kinds
    send_txn(MODE_PUSH_FRONT, 8'd0, 32'sh5555_5555);
    send_txn(MODE_PUSH_BACK, 8'd0, 32'shaaaa_aaaa);
    send_txn(MODE_INSERT, 8'd3, 32'sd1);
    // remove right at the count is a bad position, then last and first slots
    send_txn(MODE_REMOVE, 8'd16, 32'sd0);
    send_txn(MODE_REMOVE, 8'd15, 32'sd0);
    send_txn(MODE_REMOVE, 8'd0, 32'sd0);
    send_txn(MODE_POP_FRONT, 8'd0, 32'sd0);
    send_txn(MODE_POP_BACK, 8'd0, 32'sd0);
    send_txn(MODE_CLEAR, 8'd0, 32'sd0);
    send_txn(MODE_POP_BACK, 8'd0, 32'sd0);

    // random part: phases of filling, draining and mixed traffic
    phase_len = 0;
    ph        = PH_FILL;
    while (sent < NumItems) begin
      if (phase_len == 0) begin
        case ($urandom_range(0, 2))
          0:       ph = PH_FILL;
          1:       ph = PH_DRAIN;
          default: ph = PH_MIXED;
        endcase
        phase_len = $urandom_range(20, 60);
        tx_quiet  = ($urandom_range(0, 3) == 0);
      end
      phase_len--;
      if (sent == 300 || sent == 650) hold_req = 1'b1;
      m = pick_mode(ph);
      // positions mostly near the live range, sometimes anywhere
      p = ($urandom_range(0, 99) < 80) ? 8'($urandom_range(0, 17)) : 8'($urandom_range(0, 255));
      v = $urandom;
      send_txn(m, p, v);
      sender_gap();
    end
    in_valid <= 1'b0;

    // one edge so the checker has logged the last transaction, then drain
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (5) @(posedge clk);

    $display("run: %0d transactions sent, %0d results checked", sent, checked);
    $display("run: status hits empty %0d, full %0d, bad position %0d",
             empty_hits, full_hits, badpos_hits);
    if (fail_cnt == 0 && pending == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

// ===== files.f =====
rtl/bid_pkg.sv
rtl/bid_cell.sv
rtl/bounded_indexed_deque_core.sv
sim/deque_checker.sv
sim/tb_top.sv
